/* hdl/multi_list_node_pool_defines.svh */
// Assertion macros for the node pool block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef MULTI_LIST_NODE_POOL_DEFINES_SVH
`define MULTI_LIST_NODE_POOL_DEFINES_SVH

`ifndef SYNTHESIS
// Plain property, checked outside reset
`define MLNP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("multi_list_node_pool: check failed");
// Same-cycle implication, checked outside reset
`define MLNP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("multi_list_node_pool: check failed");
`else
`define MLNP_ASSERT(label, clk, rst_n, prop)
`define MLNP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/mlnp_pkg.sv */
// Shared types and codes for the multi-list node pool.
// No dependencies; imported by the top level.
package mlnp_pkg;

  // Width of the node-or-list field of an input beat
  localparam int ID_W = 13;

  // Command codes
  typedef enum logic [2:0] {
    CMD_QUERY    = 3'd0,
    CMD_ERASE    = 3'd1,
    CMD_INS_HEAD = 3'd2,
    CMD_INS_TAIL = 3'd3,
    CMD_UPDATE   = 3'd4
  } cmd_e;

  // Input beat
  typedef struct packed {
    logic [2:0]        command;
    logic [ID_W-1:0]   node_or_list;
    logic signed [31:0] new_value;
  } mlnp_in_t;

  // Result beat
  typedef struct packed {
    logic               prev_present;
    logic signed [31:0] prev_value;
    logic               self_present;
    logic signed [31:0] self_value;
    logic               next_present;
    logic signed [31:0] next_value;
  } mlnp_out_t;

endpackage

/* hdl/multi_list_node_pool.sv */
// Node pool holding many doubly linked lists, built around a node memory
// and a list head/tail memory. Depends on mlnp_pkg and the defines header.
//
// Usage:
//   Input channel in_valid_i / in_stall_o carries one command beat
//   (query, erase, insert at head, insert at tail, update). Only a query
//   gives a result beat on out_valid_o / out_stall_i; other commands and
//   ignored commands give none.
//   One command is worked on at a time; a bad number, list or code, or an
//   erased node, ends it early. The length of the work is set by the single
//   read port and single write port of the node memory: every neighbour
//   touched is one read-modify-write round.
//   A result waits in an output register; the next command is accepted
//   while it waits. Only a query that finishes while that register is
//   still stalled holds in its last step until the register drains.
//   After reset the list memory is swept to empty, one entry a cycle, and
//   in_stall_o stays high during the sweep. Node memory is not cleared:
//   node numbers are handed out in order and only the words of handed out
//   nodes are ever used.
`include "multi_list_node_pool_defines.svh"

module multi_list_node_pool
  import mlnp_pkg::*;
#(
  parameter int POOL_NODES = 4096,
  parameter int LIST_COUNT = 512
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  mlnp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output mlnp_out_t out_data_o
);

  localparam int NW  = $clog2(POOL_NODES + 1);
  localparam int LW  = $clog2(LIST_COUNT + 1);
  localparam int CNW = (NW > ID_W) ? NW : ID_W;
  localparam int CLW = (LW > ID_W) ? LW : ID_W;

  // Node and list memory words; node number 0 means none
  typedef struct packed {
    logic          live;
    logic [LW-1:0] owner;
    logic [NW-1:0] prev;
    logic [NW-1:0] next;
    logic [31:0]   value;
  } node_word_t;

  typedef struct packed {
    logic [NW-1:0] head;
    logic [NW-1:0] tail;
  } list_word_t;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_ISSUE = 7'b0000100,
    ST_SELF  = 7'b0001000,
    ST_NBR1  = 7'b0010000,
    ST_NBR2  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e        state_q, state_d;
  logic [LW-1:0] clr_q, clr_d;
  logic [NW-1:0] alloc_q, alloc_d;
  logic          out_valid_q, out_valid_d;

  mlnp_in_t   in_q;
  node_word_t self_q, self_d;
  logic [NW-1:0] tgt_q, tgt_d;
  mlnp_out_t  res_q, res_d;
  mlnp_out_t  out_q;

  logic in_accept;
  logic out_load;

  // Memory ports
  node_word_t    node_mem [POOL_NODES + 1];
  logic          node_re, node_we;
  logic [NW-1:0] node_ra, node_wa;
  node_word_t    node_wd, node_rd_q;

  list_word_t    list_mem [LIST_COUNT + 1];
  logic          list_re, list_we;
  logic [LW-1:0] list_ra, list_wa;
  list_word_t    list_wd, list_rd_q;

  // Decoded command fields
  logic [CNW-1:0] id_ext;
  logic [CLW-1:0] lst_ext;
  logic [NW-1:0]  node_id;
  logic [LW-1:0]  lst_id;
  logic           id_ok, lst_ok, room;
  logic [NW-1:0]  new_node;

  assign id_ext   = CNW'(in_q.node_or_list);
  assign lst_ext  = CLW'(in_q.node_or_list);
  assign node_id  = id_ext[NW-1:0];
  assign lst_id   = lst_ext[LW-1:0];
  assign id_ok    = (id_ext != '0) && (id_ext <= CNW'(alloc_q));
  assign lst_ok   = (lst_ext != '0) && (lst_ext <= CLW'(LIST_COUNT));
  assign room     = (alloc_q != NW'(POOL_NODES));
  assign new_node = alloc_q + 1'b1;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Sequence the memory rounds of one command
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    alloc_d  = alloc_q;
    self_d   = self_q;
    tgt_d    = tgt_q;
    res_d    = res_q;
    out_load = 1'b0;
    node_re  = 1'b0;
    node_ra  = '0;
    node_we  = 1'b0;
    node_wa  = '0;
    node_wd  = node_rd_q;
    list_re  = 1'b0;
    list_ra  = '0;
    list_we  = 1'b0;
    list_wa  = '0;
    list_wd  = list_rd_q;

    case (state_q)
      ST_CLEAR: begin
        // sweep the list memory to empty
        list_we = 1'b1;
        list_wa = clr_q;
        list_wd = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == LW'(LIST_COUNT)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_ISSUE;
        end
      end

      ST_ISSUE: begin
        state_d = ST_IDLE;
        case (in_q.command)
          CMD_QUERY: begin
            res_d = '0;
            if (id_ok) begin
              node_re = 1'b1;
              node_ra = node_id;
              state_d = ST_SELF;
            end else begin
              state_d = ST_OUT;
            end
          end
          CMD_ERASE, CMD_UPDATE: begin
            if (id_ok) begin
              node_re = 1'b1;
              node_ra = node_id;
              state_d = ST_SELF;
            end
          end
          CMD_INS_HEAD, CMD_INS_TAIL: begin
            if (lst_ok && room) begin
              list_re = 1'b1;
              list_ra = lst_id;
              state_d = ST_SELF;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end

      ST_SELF: begin
        state_d = ST_IDLE;
        self_d  = node_rd_q;
        case (in_q.command)
          CMD_QUERY: begin
            if (node_rd_q.live) begin
              res_d.self_present = 1'b1;
              res_d.self_value   = node_rd_q.value;
              node_re = 1'b1;
              node_ra = node_rd_q.prev;
              state_d = ST_NBR1;
            end else begin
              state_d = ST_OUT;
            end
          end
          CMD_UPDATE: begin
            if (node_rd_q.live) begin
              node_we       = 1'b1;
              node_wa       = node_id;
              node_wd.value = in_q.new_value;
            end
          end
          CMD_ERASE: begin
            if (node_rd_q.live) begin
              // retire the node, then fetch its list and successor
              node_we      = 1'b1;
              node_wa      = node_id;
              node_wd.live = 1'b0;
              list_re      = 1'b1;
              list_ra      = node_rd_q.owner;
              node_re      = 1'b1;
              node_ra      = node_rd_q.next;
              state_d      = ST_NBR1;
            end
          end
          CMD_INS_HEAD: begin
            node_we       = 1'b1;
            node_wa       = new_node;
            node_wd.live  = 1'b1;
            node_wd.owner = lst_id;
            node_wd.prev  = '0;
            node_wd.next  = list_rd_q.head;
            node_wd.value = 32'(new_node);
            list_we       = 1'b1;
            list_wa       = lst_id;
            list_wd.head  = new_node;
            list_wd.tail  = (list_rd_q.head == '0) ? new_node : list_rd_q.tail;
            alloc_d       = new_node;
            tgt_d         = list_rd_q.head;
            if (list_rd_q.head != '0) begin
              node_re = 1'b1;
              node_ra = list_rd_q.head;
              state_d = ST_NBR1;
            end
          end
          CMD_INS_TAIL: begin
            node_we       = 1'b1;
            node_wa       = new_node;
            node_wd.live  = 1'b1;
            node_wd.owner = lst_id;
            node_wd.prev  = list_rd_q.tail;
            node_wd.next  = '0;
            node_wd.value = 32'(new_node);
            list_we       = 1'b1;
            list_wa       = lst_id;
            list_wd.tail  = new_node;
            list_wd.head  = (list_rd_q.tail == '0) ? new_node : list_rd_q.head;
            alloc_d       = new_node;
            tgt_d         = list_rd_q.tail;
            if (list_rd_q.tail != '0) begin
              node_re = 1'b1;
              node_ra = list_rd_q.tail;
              state_d = ST_NBR1;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end

      ST_NBR1: begin
        state_d = ST_IDLE;
        case (in_q.command)
          CMD_QUERY: begin
            if (self_q.prev != '0) begin
              res_d.prev_present = 1'b1;
              res_d.prev_value   = node_rd_q.value;
            end
            node_re = 1'b1;
            node_ra = self_q.next;
            state_d = ST_NBR2;
          end
          CMD_ERASE: begin
            // repair head and tail, relink the successor
            list_we      = 1'b1;
            list_wa      = self_q.owner;
            list_wd.head = (list_rd_q.head == node_id) ? self_q.next : list_rd_q.head;
            list_wd.tail = (list_rd_q.tail == node_id) ? self_q.prev : list_rd_q.tail;
            if (self_q.next != '0) begin
              node_we      = 1'b1;
              node_wa      = self_q.next;
              node_wd.prev = self_q.prev;
            end
            if (self_q.prev != '0) begin
              node_re = 1'b1;
              node_ra = self_q.prev;
              state_d = ST_NBR2;
            end
          end
          CMD_INS_HEAD: begin
            node_we      = 1'b1;
            node_wa      = tgt_q;
            node_wd.prev = alloc_q;
          end
          CMD_INS_TAIL: begin
            node_we      = 1'b1;
            node_wa      = tgt_q;
            node_wd.next = alloc_q;
          end
          default: state_d = ST_IDLE;
        endcase
      end

      ST_NBR2: begin
        state_d = ST_IDLE;
        case (in_q.command)
          CMD_QUERY: begin
            if (self_q.next != '0) begin
              res_d.next_present = 1'b1;
              res_d.next_value   = node_rd_q.value;
            end
            state_d = ST_OUT;
          end
          CMD_ERASE: begin
            // relink the predecessor
            node_we      = 1'b1;
            node_wa      = self_q.prev;
            node_wd.next = self_q.next;
          end
          default: state_d = ST_IDLE;
        endcase
      end

      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Output register: load a result, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      alloc_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      alloc_q     <= alloc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= res_q;
    end
    self_q <= self_d;
    tgt_q  <= tgt_d;
    res_q  <= res_d;
  end

  // Node memory, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    if (node_re) begin
      node_rd_q <= node_mem[node_ra];
    end
  end

  // List memory, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[list_wa] <= list_wd;
    end
    if (list_re) begin
      list_rd_q <= list_mem[list_ra];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `MLNP_ASSERT(a_alloc_bound, clk_i, rst_ni, alloc_q <= NW'(POOL_NODES))
  `MLNP_ASSERT_IMP(a_alloc_step, clk_i, rst_ni, !$stable(alloc_q), alloc_q == $past(alloc_q) + 1'b1)
  `MLNP_ASSERT_IMP(a_no_rw_clash, clk_i, rst_ni, node_re && node_we, node_ra != node_wa)
  `MLNP_ASSERT_IMP(a_clear_quiet, clk_i, rst_ni, state_q == ST_CLEAR, !node_we && !out_load)

endmodule

/* sim/tb_multi_list_node_pool.sv */
// Self-checking bench for the multi-list node pool: a directed table, then
// random command traffic with a linked-list predictor and random stalls.
// Depends on mlnp_pkg and the multi_list_node_pool top level only.
module tb_multi_list_node_pool;
  import mlnp_pkg::*;

  localparam int POOL_NODES  = 4096;
  localparam int LIST_COUNT  = 512;
  localparam int ID_MAX      = (1 << ID_W) - 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_HEAD = 1000;
  localparam int RANDOM_TAIL = 450;
  localparam int QUIET_BEATS = 150;

  // Codes the block must swallow without a result
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    mlnp_in_t  beat;
    bit        typed;
    mlnp_out_t answer;
  } plan_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  mlnp_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  mlnp_out_t out_data_o;

  // Shadow of the pool contents
  logic signed [31:0] node_val  [0:POOL_NODES];
  bit [ID_W-1:0]      link_prev [0:POOL_NODES];
  bit [ID_W-1:0]      link_next [0:POOL_NODES];
  bit [ID_W-1:0]      owner_of  [0:POOL_NODES];
  bit                 node_live [0:POOL_NODES];
  bit [ID_W-1:0]      head_of   [0:LIST_COUNT];
  bit [ID_W-1:0]      tail_of   [0:LIST_COUNT];
  int unsigned        issued_nodes = 0;

  mlnp_out_t   awaited_answers [$];
  plan_row_t   directed_rows [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned list_spread = 4;
  int unsigned calm_beats = 0;
  bit          tail_quiet = 1'b0;

  multi_list_node_pool #(
    .POOL_NODES(POOL_NODES),
    .LIST_COUNT(LIST_COUNT)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic bit node_alive(input logic [ID_W-1:0] id);
    return id >= 1 && id <= issued_nodes && node_live[id];
  endfunction

  // Apply one command to the shadow pool; return 1 when a result beat is due
  function automatic bit apply_to_pool(input mlnp_in_t beat, output mlnp_out_t answer);
    logic [ID_W-1:0] id, fresh, p, q, lst;
    id = beat.node_or_list;
    answer = '0;
    apply_to_pool = 1'b0;
    case (beat.command)
      CMD_QUERY: begin
        apply_to_pool = 1'b1;
        if (node_alive(id)) begin
          p = link_prev[id];
          q = link_next[id];
          answer.self_present = 1'b1;
          answer.self_value   = node_val[id];
          if (p != 0) begin
            answer.prev_present = 1'b1;
            answer.prev_value   = node_val[p];
          end
          if (q != 0) begin
            answer.next_present = 1'b1;
            answer.next_value   = node_val[q];
          end
        end
      end
      CMD_ERASE: begin
        if (node_alive(id)) begin
          p = link_prev[id];
          q = link_next[id];
          lst = owner_of[id];
          if (q != 0) link_prev[q] = p;
          if (p != 0) link_next[p] = q;
          if (head_of[lst] == id) head_of[lst] = q;
          if (tail_of[lst] == id) tail_of[lst] = p;
          node_live[id] = 1'b0;
        end
      end
      CMD_INS_HEAD, CMD_INS_TAIL: begin
        if (id >= 1 && id <= LIST_COUNT && issued_nodes < POOL_NODES) begin
          issued_nodes++;
          fresh = ID_W'(issued_nodes);
          node_val[fresh]  = 32'(issued_nodes);
          link_prev[fresh] = '0;
          link_next[fresh] = '0;
          owner_of[fresh]  = id;
          node_live[fresh] = 1'b1;
          if (beat.command == CMD_INS_HEAD) begin
            q = head_of[id];
            link_next[fresh] = q;
            if (q == 0) tail_of[id] = fresh;
            else link_prev[q] = fresh;
            head_of[id] = fresh;
          end else begin
            p = tail_of[id];
            link_prev[fresh] = p;
            if (p == 0) head_of[id] = fresh;
            else link_next[p] = fresh;
            tail_of[id] = fresh;
          end
        end
      end
      CMD_UPDATE: begin
        if (node_alive(id)) node_val[id] = beat.new_value;
      end
      default: ;
    endcase
  endfunction

  function automatic mlnp_out_t reply(input bit pp, input logic signed [31:0] pv,
                                      input bit sp, input logic signed [31:0] sv,
                                      input bit np, input logic signed [31:0] nv);
    mlnp_out_t r;
    r.prev_present = pp;
    r.prev_value   = pv;
    r.self_present = sp;
    r.self_value   = sv;
    r.next_present = np;
    r.next_value   = nv;
    return r;
  endfunction

  function automatic plan_row_t row_of(input logic [2:0] cmd, input int id,
                                       input logic signed [31:0] val, input bit typed,
                                       input mlnp_out_t answer);
    plan_row_t r;
    r.beat.command      = cmd;
    r.beat.node_or_list = ID_W'(id);
    r.beat.new_value    = val;
    r.typed             = typed;
    r.answer            = answer;
    return r;
  endfunction

  function automatic logic signed [31:0] draw_value();
    case ($urandom_range(0, 7))
      0:       return VALUE_MIN;
      1:       return VALUE_MAX;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly handed-out nodes, sometimes none, unissued or wild numbers
  function automatic logic [ID_W-1:0] pick_node();
    if (issued_nodes == 0 || $urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0:       return '0;
        1:       return ID_W'(issued_nodes + 1);
        default: return ID_W'($urandom_range(0, ID_MAX));
      endcase
    end
    return ID_W'($urandom_range(1, issued_nodes));
  endfunction

  // Mostly the first list_spread lists, sometimes the last list or an unknown one
  function automatic logic [ID_W-1:0] pick_list();
    case ($urandom_range(0, 11))
      0:       return ($urandom_range(0, 1) != 0) ? '0
                      : ID_W'($urandom_range(LIST_COUNT + 1, ID_MAX));
      1:       return ID_W'(LIST_COUNT);
      default: return ID_W'($urandom_range(1, list_spread));
    endcase
  endfunction

  function automatic mlnp_in_t make_beat();
    mlnp_in_t    beat;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    beat.new_value = draw_value();
    if (pick < 35) begin
      beat.command      = CMD_QUERY;
      beat.node_or_list = pick_node();
    end else if (pick < 50) begin
      beat.command      = CMD_INS_HEAD;
      beat.node_or_list = pick_list();
    end else if (pick < 65) begin
      beat.command      = CMD_INS_TAIL;
      beat.node_or_list = pick_list();
    end else if (pick < 80) begin
      beat.command      = CMD_ERASE;
      beat.node_or_list = pick_node();
    end else if (pick < 93) begin
      beat.command      = CMD_UPDATE;
      beat.node_or_list = pick_node();
    end else begin
      beat.command      = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      beat.node_or_list = ID_W'($urandom_range(0, ID_MAX));
    end
    return beat;
  endfunction

  // Hold the beat on the bus until it is taken; valid stays high afterwards
  task automatic drive_beat(input mlnp_in_t beat);
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // Drop valid for a random burst now and then, with calm stretches between
  task automatic pace_sender();
    if (!tail_quiet) begin
      if (calm_beats > 0) begin
        calm_beats--;
      end else if ($urandom_range(0, 39) == 0) begin
        calm_beats = $urandom_range(20, 60);
      end else if ($urandom_range(0, 5) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_command(input mlnp_in_t beat, input bit typed,
                              input mlnp_out_t answer);
    mlnp_out_t predicted;
    drive_beat(beat);
    if (apply_to_pool(beat, predicted))
      awaited_answers.push_back(typed ? answer : predicted);
    pace_sender();
  endtask

  task automatic run_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 200 == 0) list_spread = ($urandom_range(0, 2) == 0) ? LIST_COUNT : 4;
      send_command(make_beat(), 1'b0, '0);
    end
  endtask

  // Check each result beat against the oldest prediction
  always @(posedge clk_i) begin : check_answers
    mlnp_out_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (awaited_answers.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result beat: %p", out_data_o);
        mismatch_count++;
      end else begin
        want = awaited_answers.pop_front();
        if (out_data_o !== want) begin
          if (mismatch_count < 10)
            $display("result mismatch: expected %p, got %p", want, out_data_o);
          mismatch_count++;
        end
      end
    end
  end

  // Stall the result side in random bursts, with calm stretches
  initial begin : out_stall_pattern
    int unsigned draw;
    forever begin
      @(posedge clk_i);
      if (!tail_quiet) begin
        draw = $urandom_range(0, 31);
        if (draw == 0) begin
          repeat ($urandom_range(30, 120)) @(posedge clk_i);
        end else if (draw < 5) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(1, 14)) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;

    // Directed table: empty pool, dropped inserts, a short list, extremes
    directed_rows.push_back(row_of(CMD_QUERY, 1, 0, 1'b1, '0));
    directed_rows.push_back(row_of(CMD_QUERY, 0, 0, 1'b1, '0));
    directed_rows.push_back(row_of(CMD_ERASE, 1, 0, 1'b0, '0));
    directed_rows.push_back(row_of(CMD_UPDATE, 1, VALUE_MAX, 1'b0, '0));
    directed_rows.push_back(row_of(CMD_INS_HEAD, 0, 0, 1'b0, '0));
    directed_rows.push_back(row_of(CMD_INS_TAIL, LIST_COUNT + 1, 0, 1'b0, '0));
    directed_rows.push_back(row_of(CMD_INS_HEAD, ID_MAX, -1, 1'b0, '0));
    directed_rows.push_back(row_of(CMD_INS_TAIL, 1, 0, 1'b0, '0));
    directed_rows.push_back(row_of(CMD_QUERY, 1, 0, 1'b1, reply(0, 0, 1, 1, 0, 0)));
    directed_rows.push_back(row_of(CMD_INS_HEAD, 1, 0, 1'b0, '0));
    directed_rows.push_back(row_of(CMD_INS_TAIL, LIST_COUNT, 0, 1'b0, '0));
    directed_rows.push_back(row_of(CMD_INS_TAIL, 1, 0, 1'b0, '0));
    directed_rows.push_back(row_of(CMD_QUERY, 1, 0, 1'b1, reply(1, 2, 1, 1, 1, 4)));
    directed_rows.push_back(row_of(CMD_UPDATE, 1, VALUE_MIN, 1'b0, '0));
    directed_rows.push_back(row_of(CMD_UPDATE, 4, VALUE_MAX, 1'b0, '0));
    directed_rows.push_back(row_of(CMD_QUERY, 1, 0, 1'b1,
                                   reply(1, 2, 1, VALUE_MIN, 1, VALUE_MAX)));
    directed_rows.push_back(row_of(CMD_QUERY, 3, 0, 1'b1, reply(0, 0, 1, 3, 0, 0)));
    directed_rows.push_back(row_of(CMD_QUERY, 5, 0, 1'b1, '0));
    directed_rows.push_back(row_of(CMD_ERASE, 1, 0, 1'b0, '0));
    directed_rows.push_back(row_of(CMD_QUERY, 1, 0, 1'b1, '0));
    directed_rows.push_back(row_of(CMD_QUERY, 2, 0, 1'b1, reply(0, 0, 1, 2, 1, VALUE_MAX)));
    directed_rows.push_back(row_of(CMD_UPDATE, 4, -1, 1'b0, '0));
    directed_rows.push_back(row_of(CMD_SPARE_LO, 2, 0, 1'b0, '0));
    directed_rows.push_back(row_of(CMD_SPARE_HI, ID_MAX, -1, 1'b0, '0));
    directed_rows.push_back(row_of(CMD_QUERY, 4, 0, 1'b1, reply(1, 2, 1, -1, 0, 0)));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_command(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].answer);

    run_random(RANDOM_HEAD);

    // Let every outstanding result drain before carrying on
    in_valid_i <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk_i);

    // Second random stretch, ending with no idling on either side
    run_random(RANDOM_TAIL - QUIET_BEATS);
    tail_quiet = 1'b1;
    run_random(QUIET_BEATS);

    in_valid_i <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (mismatch_count == 0 && awaited_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
